// ----- sv/gtach_pkg.sv -----
// Shared types, constants and command codes for the gated tachometer.
// No dependencies; every other file uses it by scoped names.
`default_nettype none
package gtach_pkg;

  // Counter widths
  localparam int COUNT_BITS = 24;
  localparam int TIME_BITS  = 16;

  // Config register widths
  localparam int WLEN_W = 16;
  localparam int PPR_W  = 8;

  // Speed scale: 60000 fits 16 bits
  localparam int SCALE_W = 16;
  localparam logic [SCALE_W-1:0] RPM_SCALE = 16'd60000;
  localparam int SPEED_W = 16;

  // Divider widths
  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = PPR_W + TIME_BITS;
  localparam int IT_W   = $clog2(NUM_W + 1);
  localparam int CMP_W  = (TIME_BITS > WLEN_W) ? TIME_BITS : WLEN_W;

  // Queue depths
  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // Config register reset values
  localparam logic [WLEN_W-1:0] WLEN_RESET = 16'd1000;
  localparam logic [PPR_W-1:0]  PPR_RESET  = 8'd40;

  // Bus command bytes
  localparam logic [7:0] CMD_START     = 8'h10;
  localparam logic [7:0] CMD_GET_SPEED = 8'h11;
  localparam logic [7:0] CMD_BUSY      = 8'h12;

  // Raw item kinds on the input channel
  localparam logic [1:0] CMD_KIND_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_KIND_WRITE  = 2'd1;
  localparam logic [1:0] CMD_KIND_READ   = 2'd2;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [NUM_W-1:0]      num_t;
  typedef logic [DEN_W-1:0]      den_t;
  typedef logic [IT_W-1:0]       it_t;
  typedef logic [SPEED_W-1:0]    speed_t;
  typedef logic [IQ_AW:0]        iq_cnt_t;
  typedef logic [OQ_AW:0]        oq_cnt_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_WRITE,
    KIND_READ
  } kind_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_PREP,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Channel payloads
  typedef struct packed {
    logic [1:0] command;
    logic       encoder_level;
    logic       ms_tick;
    logic [7:0] bus_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       last_byte;
  } out_item_t;

  // Classified item between front and back
  typedef struct packed {
    kind_t      kind;
    logic       level;
    logic       tick;
    logic [7:0] byte_val;
  } op_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    cnt_t             pulses;
    time_t            ms;
    logic [PPR_W-1:0] holes;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    speed_t speed;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- sv/gtach_front.sv -----
// Front end: accepts input transactions, classifies them, queues them.
// Depends on gtach_pkg.
`default_nettype none
module gtach_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire gtach_pkg::in_item_t in_data,
  output logic                    q_valid,
  output gtach_pkg::op_t          q_item,
  input  wire logic               q_pop
);

  gtach_pkg::op_t     mem [gtach_pkg::IQ_DEPTH];
  logic [gtach_pkg::IQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gtach_pkg::IQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  gtach_pkg::iq_cnt_t cnt_r, cnt_nxt;
  gtach_pkg::op_t     op;
  logic               keep;
  logic               wr_en;
  logic               rd_en;

  // Classify; the unused kind is accepted and dropped
  always_comb begin
    op.level    = in_data.encoder_level;
    op.tick     = in_data.ms_tick;
    op.byte_val = in_data.bus_byte;
    op.kind     = gtach_pkg::KIND_SAMPLE;
    keep        = 1'b1;
    case (in_data.command)
      gtach_pkg::CMD_KIND_SAMPLE: op.kind = gtach_pkg::KIND_SAMPLE;
      gtach_pkg::CMD_KIND_WRITE:  op.kind = gtach_pkg::KIND_WRITE;
      gtach_pkg::CMD_KIND_READ:   op.kind = gtach_pkg::KIND_READ;
      default:                    keep    = 1'b0;
    endcase
  end

  assign full    = (cnt_r == gtach_pkg::iq_cnt_t'(gtach_pkg::IQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem[rd_ptr_r];
  assign wr_en   = push && !full && keep;
  assign rd_en   = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + gtach_pkg::IQ_AW'(wr_en);
    rd_ptr_nxt = rd_ptr_r + gtach_pkg::IQ_AW'(rd_en);
    cnt_nxt    = cnt_r + gtach_pkg::iq_cnt_t'(wr_en) - gtach_pkg::iq_cnt_t'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/gtach_div.sv -----
// Speed unit: rounded, saturating pulses*60000/(holes*ms), one quotient bit per cycle.
// Depends on gtach_pkg.
`default_nettype none
module gtach_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gtach_pkg::div_req_t req,
  output gtach_pkg::div_rsp_t      rsp
);

  gtach_pkg::div_state_t state_r, state_nxt;

  gtach_pkg::cnt_t             pulses_r;
  gtach_pkg::time_t            ms_r;
  logic [gtach_pkg::PPR_W-1:0] holes_r;
  gtach_pkg::prod_t            prod_r;
  gtach_pkg::den_t             den_r;
  gtach_pkg::num_t             num_r;     // numerator, then quotient
  gtach_pkg::den_t             rem_r;
  gtach_pkg::it_t              it_r;
  gtach_pkg::speed_t           speed_r;

  logic [gtach_pkg::DEN_W:0]   rem_sh;
  logic [gtach_pkg::DEN_W:0]   diff;
  logic                        qbit;
  logic                        den_zero;

  assign rem_sh   = {rem_r, num_r[gtach_pkg::NUM_W-1]};
  assign diff     = rem_sh - {1'b0, den_r};
  assign qbit     = !diff[gtach_pkg::DEN_W];
  assign den_zero = (den_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtach_pkg::DIV_IDLE: if (req.start) state_nxt = gtach_pkg::DIV_MUL;
      gtach_pkg::DIV_MUL:  state_nxt = gtach_pkg::DIV_PREP;
      gtach_pkg::DIV_PREP: state_nxt = den_zero ? gtach_pkg::DIV_DONE : gtach_pkg::DIV_RUN;
      gtach_pkg::DIV_RUN:  if (it_r == '0) state_nxt = gtach_pkg::DIV_DONE;
      gtach_pkg::DIV_DONE: state_nxt = gtach_pkg::DIV_IDLE;
      default:             state_nxt = gtach_pkg::DIV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp.busy  = (state_r != gtach_pkg::DIV_IDLE);
    rsp.done  = (state_r == gtach_pkg::DIV_DONE);
    rsp.speed = speed_r;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      gtach_pkg::DIV_IDLE: begin
        pulses_r <= req.pulses;
        ms_r     <= req.ms;
        holes_r  <= req.holes;
      end
      gtach_pkg::DIV_MUL: begin
        prod_r <= gtach_pkg::prod_t'(pulses_r) * gtach_pkg::prod_t'(gtach_pkg::RPM_SCALE);
        den_r  <= gtach_pkg::den_t'(holes_r) * gtach_pkg::den_t'(ms_r);
      end
      gtach_pkg::DIV_PREP: begin
        num_r   <= gtach_pkg::num_t'(prod_r) + gtach_pkg::num_t'(den_r >> 1);
        rem_r   <= '0;
        it_r    <= gtach_pkg::it_t'(gtach_pkg::NUM_W - 1);
        speed_r <= (pulses_r != '0) ? '1 : '0;
      end
      gtach_pkg::DIV_RUN: begin
        num_r <= {num_r[gtach_pkg::NUM_W-2:0], qbit};
        rem_r <= qbit ? diff[gtach_pkg::DEN_W-1:0] : rem_sh[gtach_pkg::DEN_W-1:0];
        it_r  <= it_r - 1'b1;
        if (it_r == '0) begin
          speed_r <= (|{num_r[gtach_pkg::NUM_W-2:gtach_pkg::SPEED_W-1]}) ? '1
                     : {num_r[gtach_pkg::SPEED_W-2:0], qbit};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtach_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/gtach_back.sv -----
// Back end: window state, command handling and the result queue.
// Depends on gtach_pkg and gtach_div.
`default_nettype none
module gtach_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire gtach_pkg::op_t                q_item,
  output logic                               q_pop,
  input  wire logic [gtach_pkg::WLEN_W-1:0]  window_len,
  input  wire logic [gtach_pkg::PPR_W-1:0]   pulses_per_rev,
  output logic                               empty,
  input  wire logic                          pop,
  output gtach_pkg::out_item_t               out_data
);

  logic              pending_r, pending_nxt;
  logic              running_r, running_nxt;
  logic              prev_r, prev_nxt;
  gtach_pkg::cnt_t   edge_r, edge_nxt;
  gtach_pkg::time_t  elapsed_r, elapsed_nxt;
  gtach_pkg::speed_t speed_r, speed_nxt;
  logic [7:0]        sel_r, sel_nxt;

  gtach_pkg::out_item_t mem [gtach_pkg::OQ_DEPTH];
  logic [gtach_pkg::OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  gtach_pkg::oq_cnt_t          cnt_r;
  logic [1:0]                  n_wr;
  gtach_pkg::out_item_t        e0, e1;
  logic                        rd_en;

  gtach_pkg::div_req_t div_req;
  gtach_pkg::div_rsp_t div_rsp;

  gtach_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Take an item when the speed unit is quiet and two result slots are free
  assign q_pop = q_valid && !div_rsp.busy &&
                 (cnt_r <= gtach_pkg::oq_cnt_t'(gtach_pkg::OQ_DEPTH - 2));

  always_comb begin
    pending_nxt    = pending_r;
    running_nxt    = running_r;
    prev_nxt       = prev_r;
    edge_nxt       = edge_r;
    elapsed_nxt    = elapsed_r;
    speed_nxt      = div_rsp.done ? div_rsp.speed : speed_r;
    sel_nxt        = sel_r;
    n_wr           = 2'd0;
    e0             = '0;
    e1             = '0;
    div_req.start  = 1'b0;
    div_req.pulses = edge_r;
    div_req.ms     = elapsed_r;
    div_req.holes  = pulses_per_rev;
    if (q_pop) begin
      case (q_item.kind)
        gtach_pkg::KIND_SAMPLE: begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            running_nxt = 1'b1;
            edge_nxt    = '0;
            elapsed_nxt = '0;
            prev_nxt    = q_item.level;
          end else if (running_r) begin
            if (!prev_r && q_item.level && !(&edge_r)) begin
              edge_nxt = edge_r + 1'b1;
            end
            prev_nxt = q_item.level;
            if (q_item.tick && !(&elapsed_r)) begin
              elapsed_nxt = elapsed_r + 1'b1;
            end
            if (gtach_pkg::cmp_t'(elapsed_nxt) >= gtach_pkg::cmp_t'(window_len)) begin
              running_nxt    = 1'b0;
              div_req.start  = 1'b1;
              div_req.pulses = edge_nxt;
              div_req.ms     = elapsed_nxt;
            end
          end
        end
        gtach_pkg::KIND_WRITE: begin
          sel_nxt = q_item.byte_val;
          if (q_item.byte_val == gtach_pkg::CMD_START) begin
            pending_nxt = 1'b1;
          end
        end
        gtach_pkg::KIND_READ: begin
          if (sel_r == gtach_pkg::CMD_GET_SPEED) begin
            n_wr         = 2'd2;
            e0.read_byte = speed_r[7:0];
            e0.last_byte = 1'b0;
            e1.read_byte = speed_r[15:8];
            e1.last_byte = 1'b1;
          end else begin
            n_wr         = 2'd1;
            e0.read_byte = {7'd0, (sel_r == gtach_pkg::CMD_BUSY) && (running_r || pending_r)};
            e0.last_byte = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result queue
  assign empty    = (cnt_r == '0);
  assign out_data = mem[rd_ptr_r];
  assign rd_en    = pop && !empty;

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wr_ptr_r] <= e0;
    end
    if (n_wr == 2'd2) begin
      mem[wr_ptr_r + 1'b1] <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      pending_r <= 1'b0;
      running_r <= 1'b0;
      prev_r    <= 1'b0;
      edge_r    <= '0;
      elapsed_r <= '0;
      speed_r   <= '0;
      sel_r     <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_r + gtach_pkg::OQ_AW'(n_wr);
      rd_ptr_r  <= rd_ptr_r + gtach_pkg::OQ_AW'(rd_en);
      cnt_r     <= cnt_r + gtach_pkg::oq_cnt_t'(n_wr) - gtach_pkg::oq_cnt_t'(rd_en);
      pending_r <= pending_nxt;
      running_r <= running_nxt;
      prev_r    <= prev_nxt;
      edge_r    <= edge_nxt;
      elapsed_r <= elapsed_nxt;
      speed_r   <= speed_nxt;
      sel_r     <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/gated_tachometer_with_bus_commands_top.sv -----
// A read transaction passes through the input queue and then the result queue before its first byte shows.
// Throughput: one transaction per cycle while the back end is not held off by a speed divide or a full result queue.
// A window close stalls the back end while the divider steps through its multiply, prepare, run and done states.
// Reset: synchronous active-low rst_n empties both queues, clears window state and speed,
// and loads window_length_ms=1000, pulses_per_rev=40.
// Depends on gtach_pkg, gtach_front, gtach_back.
`default_nettype none
module gated_tachometer_with_bus_commands_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 push,
  output logic                      full,
  input  wire gtach_pkg::in_item_t  in_data,
  // result channel
  output logic                      empty,
  input  wire logic                 pop,
  output gtach_pkg::out_item_t      out_data,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Config registers: window length at 0x0, pulses per rev at 0x4.
  // Decode uses paddr[2] only; low address bits are ignored.
  logic [gtach_pkg::WLEN_W-1:0] wlen_r;
  logic [gtach_pkg::PPR_W-1:0]  ppr_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= gtach_pkg::WLEN_RESET;
      ppr_r  <= gtach_pkg::PPR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        ppr_r <= pwdata[gtach_pkg::PPR_W-1:0];
      end else begin
        wlen_r <= pwdata[gtach_pkg::WLEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {{(32 - gtach_pkg::PPR_W){1'b0}}, ppr_r};
    end else begin
      prdata = {{(32 - gtach_pkg::WLEN_W){1'b0}}, wlen_r};
    end
  end

  // Front end to back end: classified transaction queue.
  logic           q_valid;
  logic           q_pop;
  gtach_pkg::op_t q_item;

  gtach_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  // Back end executes in order; it holds off while a speed divide runs so
  // a later read always sees the new speed.
  gtach_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .window_len    (wlen_r),
    .pulses_per_rev(ppr_r),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

// ----- sv/gtach_checker.sv -----
// Port-level checker for the tachometer top, bound in below.
// Depends on gtach_pkg and gated_tachometer_with_bus_commands_top.
`default_nettype none
module gtach_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 full,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire gtach_pkg::out_item_t out_data
);

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // Both bytes of a speed read are queued together
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_data.last_byte) |=> (!empty && out_data.last_byte))
    else $error("low speed byte not followed by final byte");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind gated_tachometer_with_bus_commands_top gtach_checker u_gtach_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);
`default_nettype wire
